// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file tlt_checker.
// Needs a clock named clk and a reset named rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define TLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TLT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tlt_pkg.sv =====
// Shared types, codes and constants of the timecode lock tracker.
// No dependencies; used by timecode_lock_tracker, tlt_in_stage, tlt_track and the testbench.
`default_nettype none

package tlt_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_FRAME   = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_OFFSET  = 2'd0,
    REG_LOCK    = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 18;

  localparam logic signed [17:0] OFFSET_RESET  = 18'sd0;
  localparam logic [7:0]         LOCK_RESET    = 8'd3;
  localparam logic [15:0]        TIMEOUT_RESET = 16'd200;

  localparam logic [4:0] RATE_24 = 5'd24;
  localparam logic [4:0] RATE_25 = 5'd25;
  localparam logic [4:0] RATE_30 = 5'd30;

  localparam logic [4:0] ROLL_MIN   = 5'd23;
  localparam logic [4:0] THRESH_25  = 5'd24;
  localparam logic [4:0] THRESH_30  = 5'd28;

  localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [26:0] MS_PER_MIN  = 27'd60000;
  localparam logic [26:0] MS_PER_SEC  = 27'd1000;

  typedef struct packed {
    logic signed [17:0] offset_ms;
    logic [7:0]         lock_frames;
    logic [15:0]        timeout_ms;
  } cfg_t;

  typedef struct packed {
    func_t       func;
    logic [4:0]  frame_number;
    logic [26:0] hms_ms;
    logic [10:0] frac24;
    logic [10:0] frac25;
    logic [10:0] frac30;
  } item_t;

  // floor(y/3) for y below 4096, by reciprocal multiply
  function automatic logic [10:0] div3(input logic [11:0] y);
    logic [27:0] p;
    p = 28'(y) * 28'd21846;
    return p[26:16];
  endfunction

endpackage

`default_nettype wire

// ===== src/timecode_lock_tracker.sv =====
// Top level of the timecode lock tracker: configuration registers and the two stages.
// Depends on tlt_pkg, tlt_in_stage and tlt_track.
//
// Takes one request per clock (a 1 ms tick, a decoded timecode frame or a restart) and
// returns one result per request, passing through an input register that
// precomputes the frame's millisecond parts, then the state update and result register.
// Throughput is one request per cycle as long as results are taken; a waiting result
// holds the stages behind it. Configuration writes land at once and are meant for idle.
`default_nettype none

module timecode_lock_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [4:0]  hours,
  input  wire logic [5:0]  minutes,
  input  wire logic [5:0]  seconds,
  input  wire logic [4:0]  frame_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             locked,
  output logic             lock_changed,
  output logic [31:0]      time_ms,
  output logic [4:0]       fps,
  output logic [26:0]      frame_ms
);

  tlt_pkg::cfg_t  cfg;
  tlt_pkg::item_t s1_item;
  logic           s1_valid;
  logic           advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_ms   <= tlt_pkg::OFFSET_RESET;
      cfg.lock_frames <= tlt_pkg::LOCK_RESET;
      cfg.timeout_ms  <= tlt_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (tlt_pkg::reg_index_t'(cfg_index))
        tlt_pkg::REG_OFFSET:  cfg.offset_ms   <= $signed(cfg_data);
        tlt_pkg::REG_LOCK:    cfg.lock_frames <= cfg_data[7:0];
        tlt_pkg::REG_TIMEOUT: cfg.timeout_ms  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  tlt_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .frame_number (frame_number),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  tlt_track u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .locked       (locked),
    .lock_changed (lock_changed),
    .time_ms      (time_ms),
    .fps          (fps),
    .frame_ms     (frame_ms)
  );

endmodule

`default_nettype wire

// ===== src/tlt_in_stage.sv =====
// Input register: takes a request and precomputes its millisecond parts.
// Depends on tlt_pkg.
`default_nettype none

module tlt_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    func,
  input  wire logic [4:0]    hours,
  input  wire logic [5:0]    minutes,
  input  wire logic [5:0]    seconds,
  input  wire logic [4:0]    frame_number,
  input  wire logic          advance,
  output logic               s1_valid,
  output tlt_pkg::item_t     s1_item
);

  tlt_pkg::item_t item_next;

  always_comb begin
    item_next.func         = tlt_pkg::func_t'(func);
    item_next.frame_number = frame_number;
    item_next.hms_ms       = 27'(27'(hours) * tlt_pkg::MS_PER_HOUR
                               + 27'(minutes) * tlt_pkg::MS_PER_MIN
                               + 27'(seconds) * tlt_pkg::MS_PER_SEC);
    item_next.frac24       = tlt_pkg::div3(12'(frame_number) * 12'd125);
    item_next.frac25       = 11'(frame_number) * 11'd40;
    item_next.frac30       = tlt_pkg::div3(12'(frame_number) * 12'd100);
  end

  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlt_track.sv =====
// Lock, rate and elapsed-time state with the result register.
// Depends on tlt_pkg.
`default_nettype none

module tlt_track (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tlt_pkg::cfg_t  cfg,
  input  wire logic           s1_valid,
  input  wire tlt_pkg::item_t s1_item,
  output logic                advance,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                locked,
  output logic                lock_changed,
  output logic [31:0]         time_ms,
  output logic [4:0]          fps,
  output logic [26:0]         frame_ms
);

  logic        lock_flag, lock_flag_next;
  logic [7:0]  count, count_next;
  logic [4:0]  max_seen, max_seen_next;
  logic [4:0]  rate, rate_next;
  logic [26:0] last_time, last_time_next;
  logic [31:0] elapsed, elapsed_next;
  logic        running, running_next;
  logic        prev_locked;
  logic [10:0] frac;
  logic [31:0] elapsed_used;
  logic signed [34:0] t_sum;
  logic [31:0] time_next;

  assign advance = s1_valid && (!out_valid || out_ready);

  always_comb begin
    lock_flag_next = lock_flag;
    count_next     = count;
    max_seen_next  = max_seen;
    rate_next      = rate;
    last_time_next = last_time;
    elapsed_next   = elapsed;
    running_next   = running;
    frac           = s1_item.frac25;

    case (s1_item.func)
      tlt_pkg::FUNC_TICK: begin
        if (running && (elapsed != '1)) begin
          elapsed_next = elapsed + 32'd1;
        end
      end
      tlt_pkg::FUNC_FRAME: begin
        if ((s1_item.frame_number == 5'd0) && (max_seen >= tlt_pkg::ROLL_MIN)) begin
          if (max_seen >= tlt_pkg::THRESH_30) begin
            rate_next = tlt_pkg::RATE_30;
          end else if (max_seen >= tlt_pkg::THRESH_25) begin
            rate_next = tlt_pkg::RATE_25;
          end else begin
            rate_next = tlt_pkg::RATE_24;
          end
          max_seen_next = 5'd0;
        end else if (s1_item.frame_number > max_seen) begin
          max_seen_next = s1_item.frame_number;
        end
        case (rate_next)
          tlt_pkg::RATE_24: frac = s1_item.frac24;
          tlt_pkg::RATE_30: frac = s1_item.frac30;
          default:          frac = s1_item.frac25;
        endcase
        last_time_next = s1_item.hms_ms + 27'(frac);
        elapsed_next   = 32'd0;
        running_next   = 1'b1;
        if (count != 8'hFF) begin
          count_next = count + 8'd1;
        end
        if (count_next >= cfg.lock_frames) begin
          lock_flag_next = 1'b1;
        end
      end
      tlt_pkg::FUNC_RESTART: begin
        lock_flag_next = 1'b0;
        count_next     = 8'd0;
        max_seen_next  = 5'd0;
        rate_next      = tlt_pkg::RATE_25;
      end
      default: begin
      end
    endcase

    // drop lock once the flywheel runs out
    if (lock_flag_next && running_next
        && (elapsed_next > 32'(cfg.timeout_ms))) begin
      lock_flag_next = 1'b0;
      count_next     = 8'd0;
    end

    elapsed_used = running_next ? elapsed_next : 32'd0;
    t_sum = $signed({8'd0, last_time_next}) + $signed({3'd0, elapsed_used})
          + $signed({{17{cfg.offset_ms[17]}}, cfg.offset_ms});
    if (t_sum[34]) begin
      time_next = 32'd0;
    end else if (t_sum[33:32] != 2'd0) begin
      time_next = '1;
    end else begin
      time_next = t_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_flag   <= 1'b0;
      count       <= 8'd0;
      max_seen    <= 5'd0;
      rate        <= tlt_pkg::RATE_25;
      last_time   <= 27'd0;
      elapsed     <= 32'd0;
      running     <= 1'b0;
      prev_locked <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        lock_flag   <= lock_flag_next;
        count       <= count_next;
        max_seen    <= max_seen_next;
        rate        <= rate_next;
        last_time   <= last_time_next;
        elapsed     <= elapsed_next;
        running     <= running_next;
        prev_locked <= lock_flag_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      locked       <= lock_flag_next;
      lock_changed <= lock_flag_next != prev_locked;
      time_ms      <= time_next;
      fps          <= rate_next;
      frame_ms     <= last_time_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlt_checker.sv =====
// Port-level checks of the timecode lock tracker, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        locked,
  input wire logic        lock_changed,
  input wire logic [31:0] time_ms,
  input wire logic [4:0]  fps,
  input wire logic [26:0] frame_ms
);

  logic seen_locked;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_locked <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_locked <= locked;
    end
  end

  `TLT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")
  `TLT_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(time_ms) && $stable(locked) && $stable(frame_ms), "stalled result changed")
  `TLT_ASSERT(a_change_flag, out_valid |-> (lock_changed == (locked != seen_locked)), "lock_changed disagrees with lock history")
  `TLT_ASSERT(a_rate, out_valid |-> (fps == 5'd24 || fps == 5'd25 || fps == 5'd30), "bad frame rate")

endmodule

bind timecode_lock_tracker tlt_checker u_tlt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .locked       (locked),
  .lock_changed (lock_changed),
  .time_ms      (time_ms),
  .fps          (fps),
  .frame_ms     (frame_ms)
);

`default_nettype wire

// ===== sim/tb_timecode_lock_tracker.sv =====
// Testbench for the timecode lock tracker: a directed sequence, then random bursts of
// ticks, frames and restarts, checked against a cycle-free model of the lock, rate
// and time logic. Depends on tlt_pkg and timecode_lock_tracker.
module tb_timecode_lock_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    tlt_pkg::func_t func;
    logic [4:0]     hours;
    logic [5:0]     minutes;
    logic [5:0]     seconds;
    logic [4:0]     frame_number;
  } tc_req_t;

  typedef struct packed {
    logic        locked;
    logic        lock_changed;
    logic [31:0] time_ms;
    logic [4:0]  fps;
    logic [26:0] frame_ms;
  } tc_status_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  tlt_pkg::reg_index_t            cfg_index = tlt_pkg::REG_OFFSET;
  logic [tlt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  tlt_pkg::func_t                 func = tlt_pkg::FUNC_NONE;
  logic [4:0]                     hours = '0;
  logic [5:0]                     minutes = '0;
  logic [5:0]                     seconds = '0;
  logic [4:0]                     frame_number = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           locked;
  logic                           lock_changed;
  logic [31:0]                    time_ms;
  logic [4:0]                     fps;
  logic [26:0]                    frame_ms;

  timecode_lock_tracker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .frame_number (frame_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .locked       (locked),
    .lock_changed (lock_changed),
    .time_ms      (time_ms),
    .fps          (fps),
    .frame_ms     (frame_ms)
  );

  tc_req_t    timecode_req_q[$];
  tc_status_t expected_status_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned queued_count = 0;

  // tracker copy
  logic signed [17:0] cfg_offset = tlt_pkg::OFFSET_RESET;
  logic [7:0]         cfg_lock = tlt_pkg::LOCK_RESET;
  logic [15:0]        cfg_timeout = tlt_pkg::TIMEOUT_RESET;
  logic               lock_on = 1'b0;
  logic [7:0]         run_count = '0;
  logic [4:0]         peak_frame = '0;
  logic [4:0]         rate = tlt_pkg::RATE_25;
  logic [26:0]        frame_time = '0;
  logic [31:0]        elapsed = '0;
  logic               timer_on = 1'b0;
  logic               prev_locked = 1'b0;

  tc_req_t     cur_req;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic track_timecode(input tc_req_t r);
    longint unsigned ms;
    longint          t;
    tc_status_t      s;
    case (r.func)
      tlt_pkg::FUNC_TICK: begin
        if (timer_on && elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 1;
      end
      tlt_pkg::FUNC_FRAME: begin
        if (r.frame_number == 5'd0 && peak_frame >= tlt_pkg::ROLL_MIN) begin
          if (peak_frame >= tlt_pkg::THRESH_30) rate = tlt_pkg::RATE_30;
          else if (peak_frame >= tlt_pkg::THRESH_25) rate = tlt_pkg::RATE_25;
          else rate = tlt_pkg::RATE_24;
          peak_frame = '0;
        end else if (r.frame_number > peak_frame) begin
          peak_frame = r.frame_number;
        end
        ms = 64'(r.hours) * 64'(tlt_pkg::MS_PER_HOUR)
             + 64'(r.minutes) * 64'(tlt_pkg::MS_PER_MIN)
             + 64'(r.seconds) * 64'(tlt_pkg::MS_PER_SEC)
             + (64'(r.frame_number) * 64'(tlt_pkg::MS_PER_SEC)) / 64'(rate);
        frame_time = ms[26:0];
        elapsed = '0;
        timer_on = 1'b1;
        if (run_count != 8'd255) run_count = run_count + 1;
        if (run_count >= cfg_lock) lock_on = 1'b1;
      end
      tlt_pkg::FUNC_RESTART: begin
        lock_on = 1'b0;
        run_count = '0;
        peak_frame = '0;
        rate = tlt_pkg::RATE_25;
      end
      tlt_pkg::FUNC_NONE: ;
    endcase
    if (lock_on && timer_on && elapsed > 32'(cfg_timeout)) begin
      lock_on = 1'b0;
      run_count = '0;
    end
    t = longint'(frame_time) + longint'(cfg_offset);
    if (timer_on) t = t + longint'(elapsed);
    if (t < 0) t = 0;
    if (t > longint'(32'hFFFF_FFFF)) t = longint'(32'hFFFF_FFFF);
    s.locked = lock_on;
    s.lock_changed = lock_on != prev_locked;
    s.time_ms = t[31:0];
    s.fps = rate;
    s.frame_ms = frame_time;
    prev_locked = lock_on;
    expected_status_q.push_back(s);
  endtask

  task automatic push_req(input tlt_pkg::func_t f, input int unsigned h,
                          input int unsigned m, input int unsigned s,
                          input int unsigned fr);
    tc_req_t r;
    r.func = f;
    r.hours = 5'(h);
    r.minutes = 6'(m);
    r.seconds = 6'(s);
    r.frame_number = 5'(fr);
    timecode_req_q.push_back(r);
    queued_count++;
  endtask

  task automatic push_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_req(tlt_pkg::func_t'($urandom_range(0, 3)), $urandom_range(0, 31),
               $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31));
  endtask

  // well-formed run of frames at one rate, ticks between, the odd dropped frame
  task automatic push_frame_run(input int unsigned len);
    int unsigned fr_rate;
    int unsigned h;
    int unsigned m;
    int unsigned s;
    int unsigned f;
    int unsigned long_gap;
    int unsigned n;
    case ($urandom_range(0, 2))
      0: fr_rate = 24;
      1: fr_rate = 25;
      default: fr_rate = 30;
    endcase
    h = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 23);
    m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 59);
    s = $urandom_range(0, 59);
    f = $urandom_range(0, fr_rate - 1);
    long_gap = (cfg_timeout < 64) ? int'(cfg_timeout) + $urandom_range(0, 2) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      push_req(tlt_pkg::FUNC_FRAME, h, m, s, f);
      n = (long_gap != 0 && $urandom_range(0, 7) == 0) ? long_gap : $urandom_range(0, 1);
      for (int unsigned k = 0; k < n; k++) push_req(tlt_pkg::FUNC_TICK, 0, 0, 0, 0);
      for (int unsigned k = 0; k < (($urandom_range(0, 19) == 0) ? 2 : 1); k++) begin
        f++;
        if (f == fr_rate) begin
          f = 0;
          s++;
          if (s == 60) begin
            s = 0;
            m++;
            if (m == 60) begin
              m = 0;
              h = (h + 1) % 24;
            end
          end
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (timecode_req_q.size() != 0 || in_valid || expected_status_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_tracker(input int offset, input int unsigned lock_n,
                                 input int unsigned timeout);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= tlt_pkg::REG_OFFSET;
    cfg_data <= 18'(offset);
    @(posedge clk);
    cfg_index <= tlt_pkg::REG_LOCK;
    cfg_data <= 18'(lock_n);
    @(posedge clk);
    cfg_index <= tlt_pkg::REG_TIMEOUT;
    cfg_data <= 18'(timeout);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_offset = 18'(offset);
    cfg_lock = 8'(lock_n);
    cfg_timeout = 16'(timeout);
    @(posedge clk);
  endtask

  task automatic run_phase(input int offset, input int unsigned lock_n,
                           input int unsigned timeout, input int unsigned budget,
                           input int unsigned min_run, input int unsigned max_run);
    int unsigned sel;
    program_tracker(offset, lock_n, timeout);
    queued_count = 0;
    while (queued_count < budget) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) push_frame_run($urandom_range(min_run, max_run));
      else if (sel == 7) push_req(tlt_pkg::FUNC_RESTART, 0, 0, 0, 0);
      else push_noise($urandom_range(1, 4));
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    push_req(tlt_pkg::FUNC_NONE, 31, 63, 63, 31);
    push_req(tlt_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 0, 23);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_FRAME, 1, 2, 3, 24);
    push_req(tlt_pkg::FUNC_FRAME, 1, 2, 3, 0);
    push_req(tlt_pkg::FUNC_FRAME, 31, 63, 63, 31);
    push_req(tlt_pkg::FUNC_FRAME, 31, 63, 63, 0);
    push_req(tlt_pkg::FUNC_FRAME, 23, 59, 59, 29);
    push_req(tlt_pkg::FUNC_RESTART, 31, 63, 63, 31);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 1, 22);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 1, 0);
    push_req(tlt_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 0, 28);
    push_req(tlt_pkg::FUNC_FRAME, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_NONE, 0, 0, 0, 0);
    push_req(tlt_pkg::FUNC_RESTART, 0, 0, 0, 0);
    wait_idle();

    run_phase(-100000, 0, 1, 110, 1, 12);
    run_phase(100000, 255, 65535, 300, 256, 280);
    run_phase(0, 1, 5, 110, 1, 20);
    repeat (4)
      run_phase(int'($urandom_range(0, 200000)) - 100000, $urandom_range(1, 10),
                $urandom_range(1, 40), 60, 1, 25);
    run_phase(-131072, 3, 200, 60, 1, 25);

    repeat (10) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) track_timecode(cur_req);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (timecode_req_q.size() != 0) begin
          cur_req = timecode_req_q.pop_front();
          func <= cur_req.func;
          hours <= cur_req.hours;
          minutes <= cur_req.minutes;
          seconds <= cur_req.seconds;
          frame_number <= cur_req.frame_number;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tc_status_t exp_s;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          $error("result with no request pending");
          error_count++;
        end else begin
          exp_s = expected_status_q.pop_front();
          if (locked !== exp_s.locked) begin
            $error("locked: expected %0d, got %0d", exp_s.locked, locked);
            error_count++;
          end
          if (lock_changed !== exp_s.lock_changed) begin
            $error("lock_changed: expected %0d, got %0d", exp_s.lock_changed, lock_changed);
            error_count++;
          end
          if (time_ms !== exp_s.time_ms) begin
            $error("time_ms: expected %0d, got %0d", exp_s.time_ms, time_ms);
            error_count++;
          end
          if (fps !== exp_s.fps) begin
            $error("fps: expected %0d, got %0d", exp_s.fps, fps);
            error_count++;
          end
          if (frame_ms !== exp_s.frame_ms) begin
            $error("frame_ms: expected %0d, got %0d", exp_s.frame_ms, frame_ms);
            error_count++;
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
